### rtl/core/tgarle_pkg.sv
// Shared constants for the run-length coded targa pixel decoder.
package tgarle_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned PIX_W   = 32;
	localparam int unsigned ACC_W   = 24;
	localparam int unsigned REP_W   = 8;
	localparam int unsigned BPP_W   = 3;
	localparam int unsigned SIZE_W  = 25;
	localparam int unsigned PHASE_W = 2;

	// Width of the packed master-side data word: pixel value then repeat count.
	localparam int unsigned M_DATA_W = PIX_W + REP_W;

	// Decoder phases.
	localparam logic [PHASE_W-1:0] PH_HDR = 2'd0;
	localparam logic [PHASE_W-1:0] PH_RAW = 2'd1;
	localparam logic [PHASE_W-1:0] PH_RUN = 2'd2;
	localparam logic [PHASE_W-1:0] PH_ERR = 2'd3;

	// Configuration register indexes.
	localparam logic CFG_BPP  = 1'b0;
	localparam logic CFG_SIZE = 1'b1;

	// Header bytes at or above this value open a run packet.
	localparam logic [BYTE_W-1:0] RUN_FLAG = 8'd128;
	localparam logic [BYTE_W-1:0] RUN_BIAS = 8'd127;

	// Status codes.
	localparam logic ST_OK      = 1'b0;
	localparam logic ST_OVERRUN = 1'b1;

endpackage

### rtl/core/tga_rle_pixel_decoder.sv
// Run-length coded targa pixel decoder: packet parsing, pixel assembly and image counting.
// A pixel's last byte is registered in the input stage, and its word in the result register.
// Throughput: one byte per cycle without backpressure, set by the single decode-stage update.
// Header bytes and non-final pixel bytes produce no result word.
// Reset (arst_n low) returns the decoder to expecting a packet header, clears the error
// state and the pixel counter, and sets bytes_per_pixel to 3 and image_pixel_count to 1.
module tga_rle_pixel_decoder #(
	parameter int unsigned PIXEL_COUNT_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [tgarle_pkg::SIZE_W-1:0]   cfg_data,
	// Slave side: coded byte stream.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [tgarle_pkg::BYTE_W-1:0]   s_axis_tdata,   // [7:0] stream_byte
	// Master side: decoded pixels.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [tgarle_pkg::M_DATA_W-1:0] m_axis_tdata,   // [31:0] pixel_value, [39:32] repeat_count
	output logic                            m_axis_tlast,   // last_of_image
	output logic                            m_axis_tuser    // [0] status
);
	import tgarle_pkg::*;

	// The pixel counter must hold the full image size, so it is one bit wider than the
	// parameter. The configured size is compared against the cap at the wider of the two.
	localparam int unsigned CNT_W = PIXEL_COUNT_BITS + 1;
	localparam int unsigned EXT_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

	// Configuration registers.
	logic [BPP_W-1:0]  bpp_q;
	logic [SIZE_W-1:0] size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q  <= BPP_W'(3);
			size_q <= SIZE_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BPP:  bpp_q  <= cfg_data[BPP_W-1:0];
				CFG_SIZE: size_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	// Input stage register. The decode stage advances whenever the output register is
	// empty or being drained, so a new word is taken every cycle under no backpressure.
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	logic              advance;
	logic              do_step;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;
	assign do_step       = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// Decoder state.
	logic [PHASE_W-1:0] phase_q;
	logic [REP_W-1:0]   pkt_left_q;
	logic [REP_W-1:0]   run_len_q;
	logic [1:0]         byte_idx_q;
	logic [ACC_W-1:0]   acc_q;
	logic [CNT_W-1:0]   done_q;

	// Effective pixel size, minus one: zero acts as one byte, above four as four bytes.
	logic [1:0] bpp_m1;
	always_comb begin
		if (bpp_q == BPP_W'(0)) begin
			bpp_m1 = 2'd0;
		end else if (bpp_q > BPP_W'(4)) begin
			bpp_m1 = 2'd3;
		end else begin
			bpp_m1 = 2'(bpp_q - BPP_W'(1));
		end
	end

	// Effective image size: zero acts as one, and sizes above the counter's cap saturate.
	logic [EXT_W-1:0] size_ext;
	logic [EXT_W-1:0] cap_ext;
	logic [CNT_W-1:0] count;
	always_comb begin
		cap_ext  = EXT_W'(1) << PIXEL_COUNT_BITS;
		size_ext = (size_q == SIZE_W'(0)) ? EXT_W'(1) : EXT_W'(size_q);
		if (size_ext > cap_ext) begin
			size_ext = cap_ext;
		end
		count = CNT_W'(size_ext);
	end

	// Decode step: combinational next state and result for the byte in the input stage.
	logic [PHASE_W-1:0] phase_d;
	logic [REP_W-1:0]   pkt_left_d;
	logic [REP_W-1:0]   run_len_d;
	logic [1:0]         byte_idx_d;
	logic [ACC_W-1:0]   acc_d;
	logic [CNT_W-1:0]   done_d;
	logic               emit;
	logic [PIX_W-1:0]   pix_d;
	logic [REP_W-1:0]   rep_d;
	logic               last_d;
	logic               status_d;

	logic [PIX_W-1:0]   shifted;
	logic [CNT_W-1:0]   remaining;
	logic [CNT_W-1:0]   done_inc;
	logic [REP_W-1:0]   left_dec;

	always_comb begin
		phase_d    = phase_q;
		pkt_left_d = pkt_left_q;
		run_len_d  = run_len_q;
		byte_idx_d = byte_idx_q;
		acc_d      = acc_q;
		done_d     = done_q;
		emit       = 1'b0;
		rep_d      = REP_W'(0);
		last_d     = 1'b0;
		status_d   = ST_OK;

		shifted   = PIX_W'(byte_s1) << {byte_idx_q, 3'b000};
		pix_d     = PIX_W'(acc_q) | shifted;
		remaining = (done_q < count) ? (count - done_q) : CNT_W'(0);
		done_inc  = done_q + CNT_W'(1);
		left_dec  = (pkt_left_q != REP_W'(0)) ? (pkt_left_q - REP_W'(1)) : pkt_left_q;

		unique case (phase_q)
			PH_ERR: begin
				// Sticky error: every byte is dropped.
			end
			PH_HDR: begin
				if (byte_s1 < RUN_FLAG) begin
					pkt_left_d = byte_s1 + REP_W'(1);
					phase_d    = PH_RAW;
				end else begin
					run_len_d = byte_s1 - RUN_BIAS;
					phase_d   = PH_RUN;
				end
				byte_idx_d = 2'd0;
				acc_d      = ACC_W'(0);
			end
			default: begin
				if (byte_idx_q < bpp_m1) begin
					// More bytes of this pixel still to come.
					acc_d      = acc_q | ACC_W'(shifted);
					byte_idx_d = byte_idx_q + 2'd1;
				end else begin
					emit       = 1'b1;
					byte_idx_d = 2'd0;
					acc_d      = ACC_W'(0);
					if (remaining == CNT_W'(0)) begin
						// Image already complete, which only follows a lowered size.
						last_d   = 1'b1;
						status_d = ST_OVERRUN;
						phase_d  = PH_ERR;
					end else if (phase_q == PH_RAW) begin
						rep_d      = REP_W'(1);
						done_d     = done_inc;
						pkt_left_d = left_dec;
						if (done_inc == count) begin
							last_d = 1'b1;
							if (left_dec != REP_W'(0)) begin
								// Raw packet runs past the end of the image.
								status_d = ST_OVERRUN;
								phase_d  = PH_ERR;
							end else begin
								done_d  = CNT_W'(0);
								phase_d = PH_HDR;
							end
						end else if (left_dec == REP_W'(0)) begin
							phase_d = PH_HDR;
						end
					end else begin
						if (CNT_W'(run_len_q) > remaining) begin
							// Run overruns the image: clip to the pixels still missing.
							rep_d    = REP_W'(remaining);
							last_d   = 1'b1;
							status_d = ST_OVERRUN;
							done_d   = count;
							phase_d  = PH_ERR;
						end else begin
							rep_d  = run_len_q;
							done_d = done_q + CNT_W'(run_len_q);
							if (done_d == count) begin
								last_d = 1'b1;
								done_d = CNT_W'(0);
							end
							phase_d = PH_HDR;
						end
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR;
			pkt_left_q <= REP_W'(0);
			run_len_q  <= REP_W'(0);
			byte_idx_q <= 2'd0;
			acc_q      <= ACC_W'(0);
			done_q     <= CNT_W'(0);
		end else if (do_step) begin
			phase_q    <= phase_d;
			pkt_left_q <= pkt_left_d;
			run_len_q  <= run_len_d;
			byte_idx_q <= byte_idx_d;
			acc_q      <= acc_d;
			done_q     <= done_d;
		end
	end

	// Result register. It holds a word under backpressure while the input stage waits.
	logic                out_load;
	logic [M_DATA_W-1:0] out_data_q;
	logic                out_last_q;
	logic                out_status_q;

	assign out_load = do_step && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q   <= {rep_d, pix_d};
			out_last_q   <= last_d;
			out_status_q <= status_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_status_q;

	// An overrun word always closes the image.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_OVERRUN) |-> m_axis_tlast)
		else $error("overrun word without last_of_image");

	// A word reporting success always covers at least one pixel.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_OK) |-> (m_axis_tdata[M_DATA_W-1:PIX_W] != 8'd0))
		else $error("ok word with zero repeat count");

	// Once in the error phase, no further result is produced.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERR) |-> !out_load)
		else $error("result produced in error phase");

	// An overrun result leaves the decoder in the error phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load && (status_d == ST_OVERRUN) |=> (phase_q == PH_ERR))
		else $error("overrun did not enter error phase");

endmodule

### sim/tb.sv
// Self-checking testbench for the run-length coded targa pixel decoder.
module tb;
	import tgarle_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 1000000;
	localparam int unsigned SETTLE       = 6;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned RANDOM_BYTES = 300;
	localparam int unsigned MAX_REPORTS  = 40;
	localparam int unsigned SIZE_CAP     = 32'h0100_0000;
	localparam int unsigned SIZE_MAX     = 32'h01FF_FFFF;

	// Decoder state as the stream parser sees it.
	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [REP_W-1:0]   left;
		logic [REP_W-1:0]   run_len;
		logic [1:0]         bidx;
		logic [ACC_W-1:0]   acc;
		logic [SIZE_W-1:0]  done;
	} rle_state_t;

	// One decoded pixel word.
	typedef struct packed {
		logic [PIX_W-1:0] value;
		logic [REP_W-1:0] rep;
		logic             last;
		logic             status;
	} pixel_word_t;

	typedef enum int unsigned {OVR_RAW, OVR_RUN, OVR_EMPTY} overrun_kind_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                cfg_we        = 1'b0;
	logic                cfg_index     = CFG_BPP;
	logic [SIZE_W-1:0]   cfg_data      = '0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [BYTE_W-1:0]   s_axis_tdata  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic                m_axis_tlast;
	logic                m_axis_tuser;

	tga_rle_pixel_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Register copies, shared by the stimulus planner and the checker. They only
	// change while no word is in flight.
	logic [BPP_W-1:0]  cfg_bpp;
	logic [SIZE_W-1:0] cfg_size;

	// The checker follows accepted words; the planner follows queued words so that
	// the stimulus can close each image exactly.
	rle_state_t  live_st;
	rle_state_t  plan_st;
	logic [BYTE_W-1:0] coded_bytes[$];
	pixel_word_t pixel_due[$];
	pixel_word_t due_word;
	pixel_word_t seen_word;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned bytes_queued   = 0;
	int unsigned fail_count     = 0;
	int unsigned cycle_count    = 0;
	int unsigned hold_ask       = 0;
	int unsigned hold_seen      = 0;
	int unsigned hold_left      = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int unsigned eff_bpp(input logic [BPP_W-1:0] r);
		if (r == 0) return 1;
		if (r > 4) return 4;
		return int'(r);
	endfunction

	function automatic int unsigned eff_size(input logic [SIZE_W-1:0] r);
		if (r == 0) return 1;
		if (32'(r) > SIZE_CAP) return SIZE_CAP;
		return 32'(r);
	endfunction

	// Consumes one coded byte; returns 1 when it completes a pixel word.
	function automatic bit decode_byte(inout rle_state_t st, input logic [BPP_W-1:0] bpp_reg,
			input logic [SIZE_W-1:0] size_reg, input logic [BYTE_W-1:0] b,
			output pixel_word_t w);
		int unsigned total;
		int unsigned missing;
		logic [PIX_W-1:0] merged;
		w = '0;
		if (st.phase == PH_ERR) return 1'b0;
		if (st.phase == PH_HDR) begin
			if (b < RUN_FLAG) begin
				st.left = b + 8'd1;
				st.phase = PH_RAW;
			end else begin
				st.run_len = b - RUN_BIAS;
				st.phase = PH_RUN;
			end
			st.bidx = '0;
			st.acc = '0;
			return 1'b0;
		end
		merged = {8'h00, st.acc} | ({24'h000000, b} << (8 * st.bidx));
		if (32'(st.bidx) + 1 < eff_bpp(bpp_reg)) begin
			st.acc = merged[ACC_W-1:0];
			st.bidx = st.bidx + 2'd1;
			return 1'b0;
		end
		w.value = merged;
		st.bidx = '0;
		st.acc = '0;
		total = eff_size(size_reg);
		missing = (32'(st.done) < total) ? total - 32'(st.done) : 0;
		if (missing == 0) begin
			// The size was lowered below the pixels already counted.
			w.last = 1'b1;
			w.status = ST_OVERRUN;
			st.phase = PH_ERR;
		end else if (st.phase == PH_RAW) begin
			w.rep = 8'd1;
			st.done = st.done + 1'b1;
			if (st.left != 0) st.left = st.left - 8'd1;
			if (32'(st.done) == total) begin
				w.last = 1'b1;
				if (st.left != 0) begin
					w.status = ST_OVERRUN;
					st.phase = PH_ERR;
				end else begin
					st.done = '0;
					st.phase = PH_HDR;
				end
			end else if (st.left == 0) begin
				st.phase = PH_HDR;
			end
		end else begin
			if (32'(st.run_len) > missing) begin
				w.rep = missing[REP_W-1:0];
				w.last = 1'b1;
				w.status = ST_OVERRUN;
				st.done = total[SIZE_W-1:0];
				st.phase = PH_ERR;
			end else begin
				w.rep = st.run_len;
				st.done = st.done + SIZE_W'(st.run_len);
				if (32'(st.done) == total) begin
					w.last = 1'b1;
					st.done = '0;
				end
				st.phase = PH_HDR;
			end
		end
		return 1'b1;
	endfunction

	// Sender: offers the next queued word unless it rolls an idle cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (coded_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= coded_bytes.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever the stimulus asks.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_ask != hold_seen) begin
			hold_seen <= hold_ask;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Checker: predicts on every accepted input word, then compares every accepted
	// output word against the oldest prediction. Both happen here so their order is fixed.
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d pixel words outstanding", $time, pixel_due.size());
			$display("Simulation FAILED");
			$finish;
		end else if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (decode_byte(live_st, cfg_bpp, cfg_size, s_axis_tdata, due_word))
					pixel_due.push_back(due_word);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				seen_word.value = m_axis_tdata[PIX_W-1:0];
				seen_word.rep = m_axis_tdata[M_DATA_W-1:PIX_W];
				seen_word.last = m_axis_tlast;
				seen_word.status = m_axis_tuser;
				if (pixel_due.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: unexpected pixel word: expected none, got %h",
							$time, seen_word);
				end else begin
					due_word = pixel_due.pop_front();
					if (seen_word !== due_word) begin
						fail_count = fail_count + 1;
						if (fail_count <= MAX_REPORTS)
							$display({"%0t: pixel word mismatch: expected value %h rep %0d ",
								"last %0b status %0b, got value %h rep %0d last %0b status %0b"},
								$time, due_word.value, due_word.rep, due_word.last,
								due_word.status, seen_word.value, seen_word.rep,
								seen_word.last, seen_word.status);
					end
				end
			end
		end
	end

	function automatic logic [BYTE_W-1:0] rand_byte();
		logic [31:0] r;
		r = $urandom;
		return r[BYTE_W-1:0];
	endfunction

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		pixel_word_t scratch;
		coded_bytes.push_back(b);
		bytes_queued = bytes_queued + 1;
		void'(decode_byte(plan_st, cfg_bpp, cfg_size, b, scratch));
	endtask

	task automatic push_pixel();
		repeat (eff_bpp(cfg_bpp)) push_byte(rand_byte());
	endtask

	task automatic push_run(input int unsigned len);
		int unsigned hdr;
		hdr = len + 32'(RUN_BIAS);
		push_byte(hdr[BYTE_W-1:0]);
		push_pixel();
	endtask

	task automatic push_raw(input int unsigned len);
		int unsigned hdr;
		hdr = len - 1;
		push_byte(hdr[BYTE_W-1:0]);
		repeat (len) push_pixel();
	endtask

	// Well-formed packets covering exactly n pixels, mostly short ones.
	task automatic gen_pixels(input int unsigned n);
		int unsigned cap;
		int unsigned len;
		int unsigned pick;
		while (n > 0) begin
			cap = (n < 128) ? n : 128;
			pick = $urandom_range(99);
			if (pick < 80) len = $urandom_range(1, (cap < 4) ? cap : 4);
			else if (pick < 95) len = $urandom_range(1, cap);
			else len = cap;
			if ($urandom_range(1) == 1) push_run(len);
			else push_raw(len);
			n = n - len;
		end
	endtask

	// Registers change only with nothing in flight.
	task automatic write_reg(input logic idx, input int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[SIZE_W-1:0];
		if (idx == CFG_BPP) cfg_bpp = val[BPP_W-1:0];
		else cfg_size = val[SIZE_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Sender pause: every queued word accepted and every pixel word received.
	task automatic wait_idle();
		do @(negedge clk);
		while (coded_bytes.size() != 0 || s_axis_tvalid || pixel_due.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_mode(input int unsigned k);
		case (k % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
			default: begin send_idle_pct = 27; recv_stall_pct = 27; end
		endcase
	endtask

	initial begin : stimulus
		int unsigned n;
		int unsigned part;
		int unsigned start;
		int unsigned img;
		overrun_kind_t kind;

		live_st = '0;
		plan_st = '0;
		cfg_bpp = 3'd3;
		cfg_size = 25'd1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: one three-byte pixel fills the one-pixel image.
		push_byte(RUN_FLAG);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h5A);
		wait_idle();

		// Zero pixel size and zero image size both act as one.
		write_reg(CFG_BPP, 0);
		write_reg(CFG_SIZE, 0);
		push_byte(8'h00);
		push_byte(8'hFF);
		wait_idle();

		// Two longest runs fill a 256-pixel image.
		write_reg(CFG_BPP, 1);
		write_reg(CFG_SIZE, 256);
		push_byte(8'hFF);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(8'h80);
		wait_idle();

		// Two-byte pixels: a raw packet of two, then a single run.
		write_reg(CFG_BPP, 2);
		write_reg(CFG_SIZE, 3);
		push_byte(8'h01);
		push_byte(8'h34);
		push_byte(8'h12);
		push_byte(8'hFF);
		push_byte(8'hFF);
		push_byte(RUN_FLAG);
		push_byte(8'h01);
		push_byte(8'h80);
		wait_idle();

		// Oversized pixel size clamps to four bytes.
		write_reg(CFG_BPP, 7);
		write_reg(CFG_SIZE, 1);
		push_byte(RUN_FLAG);
		repeat (4) push_byte(8'hFF);
		wait_idle();

		// Pixel size shrinks after two bytes of a pixel: the next byte closes it.
		write_reg(CFG_BPP, 4);
		push_byte(RUN_FLAG);
		push_byte(8'h11);
		push_byte(8'h22);
		wait_idle();
		write_reg(CFG_BPP, 2);
		push_byte(8'h33);
		wait_idle();

		// Long receiver hold-off while the sender keeps offering words, so the
		// decoder backs up and stalls its input.
		write_reg(CFG_BPP, 1);
		write_reg(CFG_SIZE, 150);
		@(posedge clk);
		hold_ask <= hold_ask + 1;
		@(negedge clk);
		gen_pixels(150);
		wait_idle();

		// Unstructured bytes against the largest image size, then the size is
		// lowered to close the image a few pixels later.
		set_mode(3);
		write_reg(CFG_BPP, $urandom_range(2));
		write_reg(CFG_SIZE, SIZE_MAX);
		repeat (150) push_byte(rand_byte());
		while (plan_st.phase != PH_HDR) push_byte(rand_byte());
		wait_idle();
		n = $urandom_range(1, 30);
		write_reg(CFG_SIZE, 32'(plan_st.done) + n);
		gen_pixels(n);
		wait_idle();

		// Whole images with random settings, cycling through the idling modes.
		start = bytes_queued;
		img = 0;
		while (bytes_queued - start < RANDOM_BYTES) begin
			set_mode(img);
			write_reg(CFG_BPP, $urandom_range(7));
			part = $urandom_range(99);
			if (part < 5) begin
				write_reg(CFG_SIZE, 0);
				n = 1;
			end else begin
				n = (part < 75) ? $urandom_range(1, 16) : $urandom_range(17, 200);
				write_reg(CFG_SIZE, n);
			end
			gen_pixels(n);
			wait_idle();
			img = img + 1;
		end

		// The error state is sticky, so one overrun closes the run.
		set_mode($urandom_range(3));
		write_reg(CFG_BPP, $urandom_range(7));
		kind = overrun_kind_t'($urandom_range(2));
		case (kind)
			OVR_RAW: begin
				n = $urandom_range(1, 20);
				write_reg(CFG_SIZE, n);
				gen_pixels(n - 1);
				push_raw($urandom_range(2, 128));
			end
			OVR_RUN: begin
				part = $urandom_range(1, 20);
				n = part + $urandom_range(20);
				write_reg(CFG_SIZE, n);
				gen_pixels(n - part);
				push_run($urandom_range(part + 1, 128));
			end
			default: begin
				// Size drops to or below the pixels already counted.
				write_reg(CFG_SIZE, SIZE_CAP);
				n = $urandom_range(1, 30);
				gen_pixels(n);
				wait_idle();
				write_reg(CFG_SIZE, $urandom_range(n));
				push_byte(rand_byte());
				push_pixel();
			end
		endcase
		// Everything after the overrun must be swallowed.
		repeat (20) push_byte(rand_byte());
		wait_idle();

		if (fail_count == 0 && pixel_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
